[hw/rtl/paqc_pkg.sv]
`timescale 1ns / 1ps

package paqc_pkg;

    localparam int ROWS      = 6;
    localparam int CHANNELS  = 3;
    localparam int CONC_W    = 14;
    localparam int IDX_W     = 10;
    localparam int RGB_W     = 24;
    localparam int MS_W      = 32;
    localparam int ROW_W     = 3;
    localparam int DELTA_W   = 8;
    localparam int NUM_W     = 22;
    localparam int QUO_W     = 16;
    localparam int RECIP_SH  = 32;

    localparam int CH_PM1  = 0;
    localparam int CH_PM25 = 1;
    localparam int CH_PM10 = 2;

    localparam logic [IDX_W-1:0] INDEX_MAX = 10'd1023;
    localparam logic [MS_W-1:0]  WARMUP_RESET = 32'd60000;

    localparam logic [RGB_W-1:0] RGB_GOOD      = 24'h00B050;
    localparam logic [RGB_W-1:0] RGB_MODERATE  = 24'h92D050;
    localparam logic [RGB_W-1:0] RGB_SENSITIVE = 24'hFFFF00;
    localparam logic [RGB_W-1:0] RGB_UNHEALTHY = 24'hFF9900;
    localparam logic [RGB_W-1:0] RGB_VERY_BAD  = 24'hFF0000;
    localparam logic [RGB_W-1:0] RGB_HAZARD    = 24'h7E0023;
    localparam logic [RGB_W-1:0] RGB_WHITE     = 24'hFFFFFF;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic [CONC_W-1:0] lo;
        logic [CONC_W-1:0] hi;
        logic [IDX_W-1:0]  aqi_lo;
        logic [IDX_W-1:0]  aqi_hi;
    } t_seg;

    localparam t_seg SEG_TAB [0:CHANNELS-1][0:ROWS-1] = '{
        '{'{14'd0,    14'd100,  10'd0,   10'd50},
          '{14'd101,  14'd200,  10'd51,  10'd100},
          '{14'd201,  14'd300,  10'd101, 10'd150},
          '{14'd301,  14'd500,  10'd151, 10'd200},
          '{14'd501,  14'd750,  10'd201, 10'd300},
          '{14'd751,  14'd5000, 10'd301, 10'd500}},
        '{'{14'd0,    14'd159,  10'd0,   10'd50},
          '{14'd160,  14'd259,  10'd51,  10'd100},
          '{14'd260,  14'd379,  10'd101, 10'd150},
          '{14'd380,  14'd509,  10'd151, 10'd200},
          '{14'd510,  14'd759,  10'd201, 10'd300},
          '{14'd760,  14'd5000, 10'd301, 10'd500}},
        '{'{14'd0,    14'd549,  10'd0,   10'd50},
          '{14'd550,  14'd1549, 10'd51,  10'd100},
          '{14'd1550, 14'd2549, 10'd101, 10'd150},
          '{14'd2550, 14'd3549, 10'd151, 10'd200},
          '{14'd3550, 14'd4249, 10'd201, 10'd300},
          '{14'd4250, 14'd6049, 10'd301, 10'd500}}
    };

    // floor(2^32 / (hi - lo)) for each row
    localparam logic [31:0] RECIP_TAB [0:CHANNELS-1][0:ROWS-1] = '{
        '{32'((64'd1 << RECIP_SH) / 64'd100),  32'((64'd1 << RECIP_SH) / 64'd99),
          32'((64'd1 << RECIP_SH) / 64'd99),   32'((64'd1 << RECIP_SH) / 64'd199),
          32'((64'd1 << RECIP_SH) / 64'd249),  32'((64'd1 << RECIP_SH) / 64'd4249)},
        '{32'((64'd1 << RECIP_SH) / 64'd159),  32'((64'd1 << RECIP_SH) / 64'd99),
          32'((64'd1 << RECIP_SH) / 64'd119),  32'((64'd1 << RECIP_SH) / 64'd129),
          32'((64'd1 << RECIP_SH) / 64'd249),  32'((64'd1 << RECIP_SH) / 64'd4240)},
        '{32'((64'd1 << RECIP_SH) / 64'd549),  32'((64'd1 << RECIP_SH) / 64'd999),
          32'((64'd1 << RECIP_SH) / 64'd999),  32'((64'd1 << RECIP_SH) / 64'd999),
          32'((64'd1 << RECIP_SH) / 64'd699),  32'((64'd1 << RECIP_SH) / 64'd1799)}
    };

    function automatic logic [RGB_W-1:0] band_rgb(input logic [IDX_W-1:0] idx);
        logic [RGB_W-1:0] rgb;
        if (idx <= 10'd50) begin
            rgb = RGB_GOOD;
        end else if (idx <= 10'd100) begin
            rgb = RGB_MODERATE;
        end else if (idx <= 10'd200) begin
            rgb = RGB_SENSITIVE;
        end else if (idx <= 10'd300) begin
            rgb = RGB_UNHEALTHY;
        end else if (idx <= 10'd400) begin
            rgb = RGB_VERY_BAD;
        end else begin
            rgb = RGB_HAZARD;
        end
        return rgb;
    endfunction

endpackage

[hw/rtl/particulate_aqi_and_color_unit.sv]
`timescale 1ns / 1ps
// Particulate air-quality sub-index and color unit.
// Input stream (s_axis_*): one transaction carries PM1, PM2.5 and PM10
// concentrations in 0.1 ug/m3 units and the milliseconds since start.
// Output stream (m_axis_*): one transaction per input, with the three
// sub-indexes, the overall index (greater of PM2.5 and PM10) and the four
// matching band colors, all forced white while ms_since_start < warm-up.
// Configuration (i_cfg_*): writes the 32-bit warm-up time in ms; accepted
// every cycle, write it only while no transaction is in flight.
// Throughput is one transaction per cycle while the receiver accepts:
// a five-stage interpolation pipeline (segment search, offset, multiply,
// reciprocal divide, correction) plus the output register, with every
// stage advancing together.
// When the receiver stalls with an output held, the whole pipeline freezes
// and s_axis_tready drops; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and sets the
// warm-up time to 60000 ms.

module particulate_aqi_and_color_unit #(
    parameter int MAX_CONC_TENTHS = 9999
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pm1_tenths[13:0], pm25_tenths[27:14], pm10_tenths[41:28],
    // ms_since_start[73:42], zero pad[79:74]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pm1_index[9:0], pm25_index[19:10], pm10_index[29:20],
    // overall_index[39:30], pm1_rgb[63:40], pm25_rgb[87:64],
    // pm10_rgb[111:88], overall_rgb[135:112]
    output logic [135:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);

    localparam int DEPTH = 5;

    logic                         w_en;
    logic [paqc_pkg::MS_W-1:0]    r_warmup;
    logic [DEPTH-1:0]             r_vld;
    logic [DEPTH-1:0]             r_warm;
    logic                         r_ovalid;
    logic [135:0]                 r_odata;
    logic [135:0]                 n_odata;
    logic [paqc_pkg::IDX_W-1:0]   w_idx1;
    logic [paqc_pkg::IDX_W-1:0]   w_idx25;
    logic [paqc_pkg::IDX_W-1:0]   w_idx10;
    logic [paqc_pkg::IDX_W-1:0]   w_ovr;

    // advance everything unless a finished result is held
    assign w_en          = !r_ovalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup <= paqc_pkg::WARMUP_RESET;
        end else if (i_cfg_valid) begin
            r_warmup <= i_cfg_data;
        end
    end

    paqc_subidx #(.CH_SEL(paqc_pkg::CH_PM1), .MAX_CONC(MAX_CONC_TENTHS)) u_pm1 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_conc  (s_axis_tdata[13:0]),
        .o_index (w_idx1)
    );

    paqc_subidx #(.CH_SEL(paqc_pkg::CH_PM25), .MAX_CONC(MAX_CONC_TENTHS)) u_pm25 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_conc  (s_axis_tdata[27:14]),
        .o_index (w_idx25)
    );

    paqc_subidx #(.CH_SEL(paqc_pkg::CH_PM10), .MAX_CONC(MAX_CONC_TENTHS)) u_pm10 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_conc  (s_axis_tdata[41:28]),
        .o_index (w_idx10)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_vld    <= {r_vld[DEPTH-2:0], s_axis_tvalid};
            r_ovalid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_warm  <= {r_warm[DEPTH-2:0], (s_axis_tdata[73:42] < r_warmup)};
            r_odata <= n_odata;
        end
    end

    always_comb begin
        w_ovr = (w_idx25 > w_idx10) ? w_idx25 : w_idx10;
        n_odata[9:0]   = w_idx1;
        n_odata[19:10] = w_idx25;
        n_odata[29:20] = w_idx10;
        n_odata[39:30] = w_ovr;
        if (r_warm[DEPTH-1]) begin
            n_odata[63:40]   = paqc_pkg::RGB_WHITE;
            n_odata[87:64]   = paqc_pkg::RGB_WHITE;
            n_odata[111:88]  = paqc_pkg::RGB_WHITE;
            n_odata[135:112] = paqc_pkg::RGB_WHITE;
        end else begin
            n_odata[63:40]   = paqc_pkg::band_rgb(w_idx1);
            n_odata[87:64]   = paqc_pkg::band_rgb(w_idx25);
            n_odata[111:88]  = paqc_pkg::band_rgb(w_idx10);
            n_odata[135:112] = paqc_pkg::band_rgb(w_ovr);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

[hw/rtl/paqc_subidx.sv]
`timescale 1ns / 1ps

module paqc_subidx #(
    parameter int CH_SEL   = 0,
    parameter int MAX_CONC = 9999
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [paqc_pkg::CONC_W-1:0]  i_conc,
    output logic [paqc_pkg::IDX_W-1:0]   o_index
);

    localparam int RW = paqc_pkg::ROW_W;

    // stage 1: clamp and segment search
    logic [paqc_pkg::CONC_W-1:0] n1_v;
    logic [RW-1:0]               n1_row;
    logic [paqc_pkg::CONC_W-1:0] r1_v;
    logic [RW-1:0]               r1_row;

    // stage 2: offset into segment
    logic [paqc_pkg::CONC_W-1:0] n2_dv;
    logic [paqc_pkg::CONC_W-1:0] r2_dv;
    logic [RW-1:0]               r2_row;

    // stage 3: scaled numerator
    paqc_pkg::t_seg              s3_seg;
    logic [paqc_pkg::DELTA_W-1:0] s3_delta;
    logic [paqc_pkg::NUM_W-1:0]  n3_num;
    logic [paqc_pkg::NUM_W-1:0]  r3_num;
    logic [RW-1:0]               r3_row;

    // stage 4: reciprocal quotient estimate
    logic [paqc_pkg::NUM_W+31:0] n4_prod;
    logic [paqc_pkg::QUO_W-1:0]  r4_qe;
    logic [paqc_pkg::NUM_W-1:0]  r4_num;
    logic [RW-1:0]               r4_row;

    // stage 5: correct by one, add base, saturate
    paqc_pkg::t_seg              s5_seg;
    logic [paqc_pkg::CONC_W-1:0] s5_div;
    logic [paqc_pkg::NUM_W-1:0]  s5_back;
    logic [paqc_pkg::NUM_W-1:0]  s5_rem;
    logic [paqc_pkg::QUO_W:0]    s5_q;
    logic [paqc_pkg::QUO_W+1:0]  s5_sum;
    logic [paqc_pkg::IDX_W-1:0]  n5_idx;
    logic [paqc_pkg::IDX_W-1:0]  r5_idx;

    always_comb begin
        if ({2'b00, i_conc} > 16'(MAX_CONC)) begin
            n1_v = paqc_pkg::CONC_W'(MAX_CONC);
        end else begin
            n1_v = i_conc;
        end
        n1_row = RW'(paqc_pkg::ROWS - 1);
        // scan downward so the first matching row wins
        for (int k = paqc_pkg::ROWS - 1; k >= 0; k--) begin
            if (n1_v >= paqc_pkg::SEG_TAB[CH_SEL][k].lo &&
                n1_v <= paqc_pkg::SEG_TAB[CH_SEL][k].hi) begin
                n1_row = RW'(k);
            end
        end
    end

    always_comb begin
        if (r1_v < paqc_pkg::SEG_TAB[CH_SEL][r1_row].lo) begin
            n2_dv = '0;
        end else begin
            n2_dv = r1_v - paqc_pkg::SEG_TAB[CH_SEL][r1_row].lo;
        end
    end

    always_comb begin
        s3_seg   = paqc_pkg::SEG_TAB[CH_SEL][r2_row];
        s3_delta = paqc_pkg::DELTA_W'(s3_seg.aqi_hi - s3_seg.aqi_lo);
        n3_num   = {{(paqc_pkg::NUM_W-paqc_pkg::DELTA_W){1'b0}}, s3_delta}
                 * {{(paqc_pkg::NUM_W-paqc_pkg::CONC_W){1'b0}}, r2_dv};
    end

    assign n4_prod = {32'd0, r3_num} * {{paqc_pkg::NUM_W{1'b0}},
                                        paqc_pkg::RECIP_TAB[CH_SEL][r3_row]};

    always_comb begin
        s5_seg  = paqc_pkg::SEG_TAB[CH_SEL][r4_row];
        s5_div  = s5_seg.hi - s5_seg.lo;
        s5_back = {{(paqc_pkg::NUM_W-paqc_pkg::QUO_W){1'b0}}, r4_qe}
                * {{(paqc_pkg::NUM_W-paqc_pkg::CONC_W){1'b0}}, s5_div};
        s5_rem  = r4_num - s5_back;
        // the estimate is low by at most one
        s5_q    = {1'b0, r4_qe} + ((s5_rem >= paqc_pkg::NUM_W'(s5_div)) ? 17'd1 : 17'd0);
        s5_sum  = {1'b0, s5_q} + (paqc_pkg::QUO_W+2)'(s5_seg.aqi_lo);
        if (s5_sum > (paqc_pkg::QUO_W+2)'(paqc_pkg::INDEX_MAX)) begin
            n5_idx = paqc_pkg::INDEX_MAX;
        end else begin
            n5_idx = s5_sum[paqc_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v   <= n1_v;
            r1_row <= n1_row;
            r2_dv  <= n2_dv;
            r2_row <= r1_row;
            r3_num <= n3_num;
            r3_row <= r2_row;
            r4_qe  <= n4_prod[paqc_pkg::RECIP_SH +: paqc_pkg::QUO_W];
            r4_num <= r3_num;
            r4_row <= r3_row;
            r5_idx <= n5_idx;
        end
    end

    assign o_index = r5_idx;

endmodule

[sim/aqi_checker.sv]
`timescale 1ns / 1ps

module aqi_checker #(
    parameter int MAX_CONC_TENTHS = 9999
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    // pm1_tenths[13:0], pm25_tenths[27:14], pm10_tenths[41:28],
    // ms_since_start[73:42], zero pad[79:74]
    input  logic [79:0]  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    // pm1_index[9:0], pm25_index[19:10], pm10_index[29:20],
    // overall_index[39:30], pm1_rgb[63:40], pm25_rgb[87:64],
    // pm10_rgb[111:88], overall_rgb[135:112]
    input  logic [135:0] i_out_data,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [31:0]  i_cfg_data,
    output int           o_error_count,
    output int           o_pending
);

    localparam int NUM_ROWS = 6;
    localparam int unsigned IDX_LIMIT = 1023;
    localparam logic [31:0] WARMUP_DEFAULT = 32'd60000;

    localparam logic [23:0] COLOR_GOOD      = 24'h00B050;
    localparam logic [23:0] COLOR_MODERATE  = 24'h92D050;
    localparam logic [23:0] COLOR_SENSITIVE = 24'hFFFF00;
    localparam logic [23:0] COLOR_UNHEALTHY = 24'hFF9900;
    localparam logic [23:0] COLOR_VERY_BAD  = 24'hFF0000;
    localparam logic [23:0] COLOR_HAZARD    = 24'h7E0023;
    localparam logic [23:0] COLOR_WHITE     = 24'hFFFFFF;

    // breakpoint tables per channel: PM1, PM2.5, PM10
    localparam int unsigned CONC_LO [0:2][0:5] = '{
        '{0, 101, 201, 301, 501, 751},
        '{0, 160, 260, 380, 510, 760},
        '{0, 550, 1550, 2550, 3550, 4250}};
    localparam int unsigned CONC_HI [0:2][0:5] = '{
        '{100, 200, 300, 500, 750, 5000},
        '{159, 259, 379, 509, 759, 5000},
        '{549, 1549, 2549, 3549, 4249, 6049}};
    localparam int unsigned IDX_LO [0:5] = '{0, 51, 101, 151, 201, 301};
    localparam int unsigned IDX_HI [0:5] = '{50, 100, 150, 200, 300, 500};

    // laid out so the first member sits in the top bits of tdata
    typedef struct packed {
        logic [23:0] overall_rgb;
        logic [23:0] pm10_rgb;
        logic [23:0] pm25_rgb;
        logic [23:0] pm1_rgb;
        logic [9:0]  overall_idx;
        logic [9:0]  pm10_idx;
        logic [9:0]  pm25_idx;
        logic [9:0]  pm1_idx;
    } t_aqi_result;

    t_aqi_result expected_results [$];
    logic [31:0] warmup_ms;
    int          mismatches;
    int          queued;

    assign o_error_count = mismatches;
    assign o_pending     = queued;

    function automatic logic [9:0] interp_index(input int ch, input logic [13:0] raw);
        longint unsigned v;
        longint unsigned q;
        int r;
        int hit;
        v = 64'(raw);
        if (v > 64'(MAX_CONC_TENTHS)) v = 64'(MAX_CONC_TENTHS);
        hit = NUM_ROWS - 1;
        // scan downward so the first matching row wins
        for (r = NUM_ROWS - 1; r >= 0; r--) begin
            if (v >= CONC_LO[ch][r] && v <= CONC_HI[ch][r]) hit = r;
        end
        if (v < CONC_LO[ch][hit]) v = CONC_LO[ch][hit];
        q = IDX_LO[hit] + (IDX_HI[hit] - IDX_LO[hit]) * (v - CONC_LO[ch][hit])
            / (CONC_HI[ch][hit] - CONC_LO[ch][hit]);
        if (q > IDX_LIMIT) q = IDX_LIMIT;
        return q[9:0];
    endfunction

    function automatic logic [23:0] band_color(input logic [9:0] idx, input logic warm);
        if (warm) return COLOR_WHITE;
        if (idx <= 10'd50) return COLOR_GOOD;
        if (idx <= 10'd100) return COLOR_MODERATE;
        if (idx <= 10'd200) return COLOR_SENSITIVE;
        if (idx <= 10'd300) return COLOR_UNHEALTHY;
        if (idx <= 10'd400) return COLOR_VERY_BAD;
        return COLOR_HAZARD;
    endfunction

    function automatic t_aqi_result predict_reading(input logic [79:0] d,
                                                    input logic [31:0] warm_limit);
        t_aqi_result res;
        logic        warm;
        warm = d[73:42] < warm_limit;
        res.pm1_idx     = interp_index(0, d[13:0]);
        res.pm25_idx    = interp_index(1, d[27:14]);
        res.pm10_idx    = interp_index(2, d[41:28]);
        res.overall_idx = (res.pm25_idx > res.pm10_idx) ? res.pm25_idx : res.pm10_idx;
        res.pm1_rgb     = band_color(res.pm1_idx, warm);
        res.pm25_rgb    = band_color(res.pm25_idx, warm);
        res.pm10_rgb    = band_color(res.pm10_idx, warm);
        res.overall_rgb = band_color(res.overall_idx, warm);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic compare_result(input t_aqi_result got, input t_aqi_result want);
        if (got.pm1_idx !== want.pm1_idx)
            report_mismatch("pm1_index", 32'(got.pm1_idx), 32'(want.pm1_idx));
        if (got.pm25_idx !== want.pm25_idx)
            report_mismatch("pm25_index", 32'(got.pm25_idx), 32'(want.pm25_idx));
        if (got.pm10_idx !== want.pm10_idx)
            report_mismatch("pm10_index", 32'(got.pm10_idx), 32'(want.pm10_idx));
        if (got.overall_idx !== want.overall_idx)
            report_mismatch("overall_index", 32'(got.overall_idx), 32'(want.overall_idx));
        if (got.pm1_rgb !== want.pm1_rgb)
            report_mismatch("pm1_rgb", 32'(got.pm1_rgb), 32'(want.pm1_rgb));
        if (got.pm25_rgb !== want.pm25_rgb)
            report_mismatch("pm25_rgb", 32'(got.pm25_rgb), 32'(want.pm25_rgb));
        if (got.pm10_rgb !== want.pm10_rgb)
            report_mismatch("pm10_rgb", 32'(got.pm10_rgb), 32'(want.pm10_rgb));
        if (got.overall_rgb !== want.overall_rgb)
            report_mismatch("overall_rgb", 32'(got.overall_rgb), 32'(want.overall_rgb));
    endtask

    initial begin
        mismatches = 0;
        queued     = 0;
        warmup_ms  = WARMUP_DEFAULT;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            warmup_ms = WARMUP_DEFAULT;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result transaction", 32'd0, 32'd0);
                else
                    compare_result(i_out_data, expected_results.pop_front());
            end
            if (i_cfg_valid && i_cfg_ready) warmup_ms = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_reading(i_in_data, warmup_ms));
        end
        queued = expected_results.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int MAX_CONC      = 9999;
    localparam int DRAIN_CYCLES  = 10;
    localparam int SQUEEZE_LEN   = 300;
    localparam int ITEMS_PER_SET = 140;
    localparam int NUM_SETS      = 6;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data;
    int           err_count;
    int           pending;

    bit          steady;
    bit          squeeze_req;
    logic [31:0] warmup;
    int          readings_sent;
    int          stall_cycles;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    particulate_aqi_and_color_unit #(
        .MAX_CONC_TENTHS(MAX_CONC)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    aqi_checker #(
        .MAX_CONC_TENTHS(MAX_CONC)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_error_count (err_count),
        .o_pending     (pending)
    );

    function automatic logic [79:0] pack_reading(input logic [13:0] pm1,
                                                 input logic [13:0] pm25,
                                                 input logic [13:0] pm10,
                                                 input logic [31:0] ms);
        return {6'd0, ms, pm10, pm25, pm1};
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [13:0] pick_conc(input int ch);
        int r;
        int row;
        int v;
        r   = $urandom_range(0, 9);
        row = $urandom_range(0, paqc_pkg::ROWS - 1);
        case (r)
            0, 1, 2, 3, 4, 5:
                v = $urandom_range(0,
                        int'(paqc_pkg::SEG_TAB[ch][paqc_pkg::ROWS-1].hi) + 200);
            6: v = int'(paqc_pkg::SEG_TAB[ch][row].lo) + $urandom_range(0, 2) - 1;
            7: v = int'(paqc_pkg::SEG_TAB[ch][row].hi) + $urandom_range(0, 2) - 1;
            8: v = $urandom_range(0, 16383);
            default: v = $urandom_range(MAX_CONC - 10, 16383);
        endcase
        if (v < 0) v = 0;
        return v[13:0];
    endfunction

    function automatic logic [31:0] pick_ms(input logic [31:0] warm);
        case ($urandom_range(0, 7))
            0: return warm - 32'd1;
            1: return warm;
            2: return warm + 32'd1;
            3: return 32'd0;
            4: return 32'hFFFF_FFFF;
            5: return warm + $urandom_range(0, 2000) - 32'd1000;
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic offer_reading(input logic [79:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge clk); while (!s_axis_tready);
        readings_sent++;
        @(negedge clk);
    endtask

    // drop valid first; waiting on the queue keeps the next drive in a later step
    task automatic set_warmup(input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge clk); while (!o_cfg_ready);
        @(negedge clk);
        i_cfg_valid <= 1'b0;
        warmup = v;
    endtask

    initial begin : sink
        int stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge clk);
            if (squeeze_req) begin
                // hold off long enough for the pipeline to back up into the input
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_LEN - 1) @(negedge clk);
                stall_cycles += SQUEEZE_LEN;
                squeeze_req = 1'b0;
            end else if (steady) begin
                m_axis_tready <= 1'b1;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
                stall_cycles++;
            end else begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        logic [79:0] directed [$];
        logic [31:0] warm_sets [NUM_SETS];
        int s;
        int n;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        steady        = 1'b0;
        squeeze_req   = 1'b0;
        warmup        = 32'd60000;
        readings_sent = 0;
        stall_cycles  = 0;

        // table edges, band edges, clamping, extrapolation and the warm-up boundary
        directed.push_back(pack_reading(14'd0, 14'd0, 14'd0, 32'd0));
        directed.push_back(pack_reading(14'd0, 14'd0, 14'd0, 32'd60000));
        directed.push_back(pack_reading(14'd100, 14'd159, 14'd549, 32'd60000));
        directed.push_back(pack_reading(14'd101, 14'd160, 14'd550, 32'd60001));
        directed.push_back(pack_reading(14'd200, 14'd259, 14'd1549, 32'd70000));
        directed.push_back(pack_reading(14'd201, 14'd260, 14'd1550, 32'd70000));
        directed.push_back(pack_reading(14'd300, 14'd379, 14'd2549, 32'd70000));
        directed.push_back(pack_reading(14'd301, 14'd380, 14'd2550, 32'd70000));
        directed.push_back(pack_reading(14'd500, 14'd509, 14'd3549, 32'd70000));
        directed.push_back(pack_reading(14'd501, 14'd510, 14'd3550, 32'd70000));
        directed.push_back(pack_reading(14'd750, 14'd759, 14'd4249, 32'd70000));
        directed.push_back(pack_reading(14'd751, 14'd760, 14'd4250, 32'd70000));
        directed.push_back(pack_reading(14'd5000, 14'd5000, 14'd6049, 32'd70000));
        directed.push_back(pack_reading(14'd5001, 14'd5001, 14'd6050, 32'd70000));
        directed.push_back(pack_reading(14'd9999, 14'd9999, 14'd9999, 32'd70000));
        directed.push_back(pack_reading(14'd10000, 14'd10000, 14'd10000, 32'd70000));
        directed.push_back(pack_reading(14'h3FFF, 14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF));
        directed.push_back(pack_reading(14'h2AAA, 14'h1555, 14'h2AAA, 32'd59999));
        directed.push_back(pack_reading(14'h1555, 14'h2AAA, 14'h1555, 32'hAAAA_AAAA));
        directed.push_back(pack_reading(14'd250, 14'd40, 14'd3000, 32'h5555_5555));
        directed.push_back(pack_reading(14'd40, 14'd700, 14'd100, 32'd80000));
        directed.push_back(pack_reading(14'd600, 14'd2869, 14'd0, 32'd80000));
        directed.push_back(pack_reading(14'd600, 14'd2870, 14'd0, 32'd80000));
        directed.push_back(pack_reading(14'd600, 14'd2891, 14'd0, 32'd80000));

        warm_sets[0] = 32'd0;
        warm_sets[1] = 32'hFFFF_FFFF;
        warm_sets[2] = 32'd60000;
        warm_sets[3] = $urandom();
        warm_sets[4] = 32'd1;
        warm_sets[5] = $urandom_range(0, 200000);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i]) offer_reading(directed[i]);

        for (s = 0; s < NUM_SETS; s++) begin
            set_warmup(warm_sets[s]);
            steady = (s == 2);
            for (n = 0; n < ITEMS_PER_SET; n++) begin
                if (s == 3 && n == 10) begin
                    steady      = 1'b1;
                    squeeze_req = 1'b1;
                end
                if (s == 3 && n == 70) steady = 1'b0;
                offer_reading(pack_reading(pick_conc(0), pick_conc(1), pick_conc(2),
                                           pick_ms(warmup)));
            end
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d readings over %0d warm-up settings, with table and band edges,",
                 readings_sent, NUM_SETS + 1);
        $display("clamped and extrapolated inputs, and %0d cycles of output back-pressure.",
                 stall_cycles);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/paqc_pkg.sv
hw/rtl/paqc_subidx.sv
hw/rtl/particulate_aqi_and_color_unit.sv
sim/aqi_checker.sv
sim/tb.sv
